[rtl/core/btk_pkg.sv]
package btk_pkg;

  // Sizing
  localparam int CAPACITY = 16;
  localparam int SLOTS    = CAPACITY + 1;
  localparam int KEY_BITS = 24;

  // Field widths
  localparam int DRAW_W = 24;
  localparam int TILE_W = 35;
  localparam int EQ_W   = 32;
  localparam int CAP_W  = 7;

  // Slot index and entry count widths
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Draw count bits that take part in the key
  localparam logic [DRAW_W-1:0] KEY_MASK = (KEY_BITS >= DRAW_W) ? {DRAW_W{1'b1}} :
                                           DRAW_W'((64'd1 << KEY_BITS) - 64'd1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DRAIN  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Outcome of the shared key compare
  typedef enum logic [2:0] {
    PICK_CUR   = 3'b001,
    PICK_LEFT  = 3'b010,
    PICK_RIGHT = 3'b100
  } pick_t;

  typedef struct packed {
    logic        [DRAW_W-1:0] key;
    logic        [TILE_W-1:0] leave;
    logic        [TILE_W-1:0] exch;
    logic signed [EQ_W-1:0]   equity;
  } entry_t;

  typedef struct packed {
    entry_t ent;
    logic   last;
    logic   empty_err;
  } result_t;

endpackage

[rtl/core/btk_key_cmp.sv]
module btk_key_cmp (
  input  logic [btk_pkg::DRAW_W-1:0] cur_key,
  input  logic [btk_pkg::DRAW_W-1:0] left_key,
  input  logic                       left_vld,
  input  logic [btk_pkg::DRAW_W-1:0] right_key,
  input  logic                       right_vld,
  output btk_pkg::pick_t             pick
);
  import btk_pkg::*;

  logic [DRAW_W-1:0] best;

  // Left wins only if strictly smaller than current, right only if strictly
  // smaller than the left/current winner
  always_comb begin
    if (left_vld && (left_key < cur_key)) begin
      pick = PICK_LEFT;
      best = left_key;
    end else begin
      pick = PICK_CUR;
      best = cur_key;
    end
    if (right_vld && (right_key < best)) begin
      pick = PICK_RIGHT;
    end
  end

endmodule

[rtl/core/btk_seq.sv]
module btk_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  btk_pkg::op_t              in_op,
  input  btk_pkg::entry_t           in_ent,
  input  logic [btk_pkg::CNT_W-1:0] eff_cap,
  output logic                      res_valid,
  input  logic                      res_ready,
  output btk_pkg::result_t          res
);
  import btk_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_RD   = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_POP_RD  = 8'b0000_1000,
    S_POP_DAT = 8'b0001_0000,
    S_DN_RD   = 8'b0010_0000,
    S_DN_CMP  = 8'b0100_0000,
    S_EMPTY   = 8'b1000_0000
  } state_t;

  // What the current pop is for
  typedef enum logic [2:0] {
    K_POP   = 3'b001,
    K_DRAIN = 3'b010,
    K_EVICT = 3'b100
  } kind_t;

  state_t            state, state_next;
  kind_t             kind, kind_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [IDX_W-1:0]  hole, hole_next;
  entry_t            mov, mov_next;

  entry_t            mem [SLOTS];
  entry_t            rd_a, rd_b;
  logic [IDX_W-1:0]  addr_a, addr_b;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic [IDX_W:0]    lidx, ridx;
  logic              lvld, rvld;
  logic [IDX_W-1:0]  parent;
  state_t            fin_state;

  logic [DRAW_W-1:0] cmp_cur, cmp_left, cmp_right;
  logic              cmp_lv, cmp_rv;
  pick_t             pick;

  // Heap geometry around the hole
  assign lidx   = {hole, 1'b1};
  assign ridx   = lidx + (IDX_W+1)'(1);
  assign lvld   = lidx < (IDX_W+1)'(count);
  assign rvld   = ridx < (IDX_W+1)'(count);
  assign parent = IDX_W'((hole - IDX_W'(1)) >> 1);

  // Where to go once a sift-down settles
  assign fin_state = ((kind == K_DRAIN) && (count != '0)) ? S_POP_RD : S_IDLE;

  assign in_ready = (state == S_IDLE);

  // Shared compare: sift-up asks "new < parent", sift-down picks min of three
  always_comb begin
    if (state == S_UP_CMP) begin
      cmp_cur   = rd_a.key;
      cmp_left  = mov.key;
      cmp_lv    = 1'b1;
      cmp_right = mov.key;
      cmp_rv    = 1'b0;
    end else begin
      cmp_cur   = mov.key;
      cmp_left  = rd_a.key;
      cmp_lv    = lvld;
      cmp_right = rd_b.key;
      cmp_rv    = rvld;
    end
  end

  btk_key_cmp u_cmp (
    .cur_key   (cmp_cur),
    .left_key  (cmp_left),
    .left_vld  (cmp_lv),
    .right_key (cmp_right),
    .right_vld (cmp_rv),
    .pick      (pick)
  );

  // Read addresses
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    unique case (state)
      S_UP_RD: begin
        addr_a = parent;
        addr_b = parent;
      end
      S_POP_RD, S_POP_DAT: begin
        addr_a = '0;
        addr_b = IDX_W'(count - CNT_W'(1));
      end
      S_DN_RD: begin
        addr_a = lvld ? lidx[IDX_W-1:0] : '0;
        addr_b = rvld ? ridx[IDX_W-1:0] : '0;
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    kind_next  = kind;
    count_next = count;
    hole_next  = hole;
    mov_next   = mov;
    wr_en      = 1'b0;
    wr_addr    = hole;
    wr_data    = mov;
    res_valid  = 1'b0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_INSERT: begin
              mov_next     = in_ent;
              mov_next.key = in_ent.key & KEY_MASK;
              hole_next    = IDX_W'(count);
              count_next   = count + CNT_W'(1);
              state_next   = S_UP_RD;
            end
            OP_POP, OP_DRAIN: begin
              kind_next  = (in_op == OP_POP) ? K_POP : K_DRAIN;
              state_next = (count == '0) ? S_EMPTY : S_POP_RD;
            end
            default: begin
              count_next = '0;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (hole == '0) begin
          wr_en = 1'b1;
          if (count > eff_cap) begin
            kind_next  = K_EVICT;
            state_next = S_POP_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (pick == PICK_LEFT) begin
          // parent moves down into the hole
          wr_data    = rd_a;
          hole_next  = parent;
          state_next = S_UP_RD;
        end else if (count > eff_cap) begin
          kind_next  = K_EVICT;
          state_next = S_POP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POP_RD: begin
        state_next = S_POP_DAT;
      end
      S_POP_DAT: begin
        res.ent   = rd_a;
        res.last  = (kind == K_POP) || (count == CNT_W'(1));
        res_valid = (kind != K_EVICT);
        if (!res_valid || res_ready) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            // last entry fills the root hole and sifts down
            mov_next   = rd_b;
            hole_next  = '0;
            state_next = S_DN_RD;
          end
        end
      end
      S_DN_RD: begin
        if (!lvld) begin
          wr_en      = 1'b1;
          state_next = fin_state;
        end else begin
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        case (pick)
          PICK_LEFT: begin
            wr_data    = rd_a;
            hole_next  = lidx[IDX_W-1:0];
            state_next = S_DN_RD;
          end
          PICK_RIGHT: begin
            wr_data    = rd_b;
            hole_next  = ridx[IDX_W-1:0];
            state_next = S_DN_RD;
          end
          default: begin
            state_next = fin_state;
          end
        endcase
      end
      S_EMPTY: begin
        res_valid     = 1'b1;
        res.last      = 1'b1;
        res.empty_err = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= K_POP;
      count <= '0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      count <= count_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    hole <= hole_next;
    mov  <= mov_next;
  end

endmodule

[rtl/core/bounded_top_k_min_heap.sv]
// Bounded min-heap that keeps the entries with the most draws.
// Input channel (in_valid/in_ready, op + entry fields): one transaction per
// operation. Insert and clear give no result; pop gives one result; drain
// gives one result per stored entry, smallest first, with last on the final
// one. A pop or drain on an empty heap gives a single result with last and
// empty_error set and all other fields zero.
// Output channel (out_valid/out_ready) is a registered stage, so a result
// may wait there while the core works on the next transaction.
// cfg_wr_en/cfg_wr_data write the capacity register (0 acts as 1, values
// above 16 act as 16); write it only while the block is idle.
// Flow: in_ready is high only when the sequencer is idle. An insert climbs
// with a read and a compare state per level and writes the entry where it
// stops; when it evicts, a pop without output follows. A pop reads the root
// and the last entry, then sifts down with a read and a compare state per
// level when entries remain; drain repeats that per entry. The rate is set
// by the single entry RAM and the one shared key comparator, one level per
// read/compare pair.
// Reset clears the heap count and sets the capacity to 16; no clearing pass.
// A stalled receiver holds the output register, and the sequencer then waits
// in front of its next result.
module bounded_top_k_min_heap (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [btk_pkg::CAP_W-1:0]         cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        op,
  input  logic [btk_pkg::DRAW_W-1:0]        draws,
  input  logic [btk_pkg::TILE_W-1:0]        leave_tiles,
  input  logic [btk_pkg::TILE_W-1:0]        exchanged_tiles,
  input  logic signed [btk_pkg::EQ_W-1:0]   equity,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [btk_pkg::DRAW_W-1:0]        out_draws,
  output logic [btk_pkg::TILE_W-1:0]        out_leave_tiles,
  output logic [btk_pkg::TILE_W-1:0]        out_exchanged_tiles,
  output logic signed [btk_pkg::EQ_W-1:0]   out_equity,
  output logic                              last,
  output logic                              empty_error
);
  import btk_pkg::*;

  logic [CAP_W-1:0] cap;
  logic [CNT_W-1:0] eff_cap;
  entry_t           in_ent;
  result_t          res, out_q;
  logic             res_valid, res_ready;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  // Clamp capacity to 1..CAPACITY
  always_comb begin
    if (cap == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap > CAP_W'(CAPACITY)) begin
      eff_cap = CNT_W'(CAPACITY);
    end else begin
      eff_cap = CNT_W'(cap);
    end
  end

  assign in_ent.key    = draws;
  assign in_ent.leave  = leave_tiles;
  assign in_ent.exch   = exchanged_tiles;
  assign in_ent.equity = equity;

  btk_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (op_t'(op)),
    .in_ent    (in_ent),
    .eff_cap   (eff_cap),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_draws           = out_q.ent.key;
  assign out_leave_tiles     = out_q.ent.leave;
  assign out_exchanged_tiles = out_q.ent.exch;
  assign out_equity          = out_q.ent.equity;
  assign last                = out_q.last;
  assign empty_error         = out_q.empty_err;

endmodule

[rtl/core/btk_checker.sv]
module btk_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        op,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [btk_pkg::DRAW_W-1:0]        out_draws,
  input logic [btk_pkg::TILE_W-1:0]        out_leave_tiles,
  input logic [btk_pkg::TILE_W-1:0]        out_exchanged_tiles,
  input logic signed [btk_pkg::EQ_W-1:0]   out_equity,
  input logic                              last,
  input logic                              empty_error
);
  import btk_pkg::*;

  // Reset empties the output stage
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // An empty report is always the final, all-zero result
  a_empty_fmt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_error) |->
      (last && (out_draws == '0) && (out_leave_tiles == '0) &&
       (out_exchanged_tiles == '0) && (out_equity == '0)))
    else $error("malformed empty result");

  // Clear leaves the sequencer ready again in the following cycle
  a_clear_fast: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (op == OP_CLEAR)) |=> in_ready)
    else $error("not ready after clear");

  // Held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_draws) && $stable(out_leave_tiles) &&
       $stable(out_exchanged_tiles) && $stable(out_equity) && $stable(last) &&
       $stable(empty_error)))
    else $error("stalled result changed");

endmodule

bind bounded_top_k_min_heap btk_checker u_btk_checker (.*);

[tb/bounded_top_k_min_heap_test.sv]
module bounded_top_k_min_heap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btk_pkg::*;

  // Cycles to let an insert (climb plus eviction) finish before a register write
  localparam int SETTLE_CYCLES = 40;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CAP_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               op;
  logic [DRAW_W-1:0]        draws;
  logic [TILE_W-1:0]        leave_tiles;
  logic [TILE_W-1:0]        exchanged_tiles;
  logic signed [EQ_W-1:0]   equity;
  logic                     out_valid;
  logic                     out_ready;
  logic [DRAW_W-1:0]        out_draws;
  logic [TILE_W-1:0]        out_leave_tiles;
  logic [TILE_W-1:0]        out_exchanged_tiles;
  logic signed [EQ_W-1:0]   out_equity;
  logic                     last;
  logic                     empty_error;

  // Shadow heap: contents, entry count and capacity register
  entry_t           shadow_heap [SLOTS];
  int unsigned      shadow_count;
  logic [CAP_W-1:0] shadow_cap;

  // Popped entries still owed by the block, oldest first
  result_t          expected_pops [$];
  int unsigned      fail_count;

  // Idle controls shared by the sender, the receiver and the tests
  bit               tx_idle_on;
  bit               rx_idle_on;
  int unsigned      rx_hold_req;

  bounded_top_k_min_heap u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .op                  (op),
    .draws               (draws),
    .leave_tiles         (leave_tiles),
    .exchanged_tiles     (exchanged_tiles),
    .equity              (equity),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_draws           (out_draws),
    .out_leave_tiles     (out_leave_tiles),
    .out_exchanged_tiles (out_exchanged_tiles),
    .out_equity          (out_equity),
    .last                (last),
    .empty_error         (empty_error)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow heap
  // ---------------------------------------------------------------------------

  // Capacity register clamped to 1..CAPACITY
  function automatic int unsigned kept_limit();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > CAPACITY) return CAPACITY;
    return 32'(shadow_cap);
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  // Climb while the parent key is strictly greater
  function automatic void climb(int unsigned i);
    int unsigned p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (shadow_heap[p].key > shadow_heap[i].key) begin
        swap_slots(p, i);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  // Left child first, right child only if strictly below the current pick
  function automatic void sink(int unsigned i);
    int unsigned l;
    int unsigned r;
    int unsigned m;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      m = i;
      if (l < shadow_count && shadow_heap[l].key < shadow_heap[i].key) m = l;
      if (r < shadow_count && shadow_heap[r].key < shadow_heap[m].key) m = r;
      if (m == i) break;
      swap_slots(m, i);
      i = m;
    end
  endfunction

  function automatic entry_t take_min();
    entry_t top;
    top = shadow_heap[0];
    shadow_count--;
    if (shadow_count > 0) begin
      swap_slots(0, shadow_count);
      sink(0);
    end
    return top;
  endfunction

  // Apply one transaction to the shadow heap and queue the results it owes
  function automatic void predict_heap_op(op_t o, entry_t e);
    result_t r;
    int unsigned i;
    r = '0;
    case (o)
      OP_INSERT: begin
        i = shadow_count;
        shadow_heap[i] = e;
        shadow_heap[i].key = e.key & KEY_MASK;
        climb(i);
        shadow_count = i + 1;
        if (shadow_count > kept_limit()) void'(take_min());
      end
      OP_POP, OP_DRAIN: begin
        if (shadow_count == 0) begin
          r.last = 1'b1;
          r.empty_err = 1'b1;
          expected_pops.push_back(r);
        end else begin
          do begin
            r.ent = take_min();
            r.last = (o == OP_POP) || (shadow_count == 0);
            expected_pops.push_back(r);
          end while (o == OP_DRAIN && shadow_count > 0);
        end
      end
      default: shadow_count = 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : pop_checker
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_pops.size() == 0) begin
        $display("%0t: result with none pending, expected none actual draws %h last %b",
                 $time, out_draws, last);
        fail_count++;
      end else begin
        want = expected_pops.pop_front();
        check_field("out_draws", 64'(want.ent.key), 64'(out_draws));
        check_field("out_leave_tiles", 64'(want.ent.leave), 64'(out_leave_tiles));
        check_field("out_exchanged_tiles", 64'(want.ent.exch),
                    64'(out_exchanged_tiles));
        check_field("out_equity", 64'(unsigned'(want.ent.equity)),
                    64'(unsigned'(out_equity)));
        check_field("last", 64'(want.last), 64'(last));
        check_field("empty_error", 64'(want.empty_err), 64'(empty_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_sink
    int unsigned hold_left;
    int unsigned stall_left;
    hold_left = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!rx_idle_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------

  // One transaction on the input channel; valid stays up if no gap follows
  task automatic send_op(op_t o, entry_t e);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= o;
    draws           <= e.key;
    leave_tiles     <= e.leave;
    exchanged_tiles <= e.exch;
    equity          <= e.equity;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_heap_op(o, e);
  endtask

  task automatic send_insert(logic [DRAW_W-1:0] k, logic [TILE_W-1:0] lv,
                             logic [TILE_W-1:0] ex, logic signed [EQ_W-1:0] eq);
    entry_t e;
    e.key = k;
    e.leave = lv;
    e.exch = ex;
    e.equity = eq;
    send_op(OP_INSERT, e);
  endtask

  // Wait for the block to go quiet, then write the capacity register
  task automatic set_capacity(logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_cap = v;
  endtask

  // Keys lean toward a narrow range so ties are common
  function automatic entry_t random_entry();
    entry_t e;
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5)      e.key = DRAW_W'($urandom_range(0, 15));
    else if (r < 8) e.key = DRAW_W'($urandom);
    else            e.key = ($urandom_range(0, 1) != 0) ? '1 : '0;
    e.leave = TILE_W'({$urandom, $urandom});
    e.exch  = ($urandom_range(0, 3) == 0) ? '0 : TILE_W'({$urandom, $urandom});
    r = $urandom_range(0, 9);
    if (r == 0)      e.equity = 32'sh8000_0000;
    else if (r == 1) e.equity = 32'sh7fff_ffff;
    else             e.equity = $urandom;
    return e;
  endfunction

  function automatic op_t random_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return OP_INSERT;
    if (r < 80) return OP_POP;
    if (r < 92) return OP_DRAIN;
    return OP_CLEAR;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pop and drain on an empty heap, clear with nothing stored
  task automatic test_empty_heap();
    send_op(OP_POP, random_entry());
    send_op(OP_DRAIN, random_entry());
    send_op(OP_CLEAR, random_entry());
  endtask

  // Field extremes, including an insert with no exchanged set
  task automatic test_field_extremes();
    send_insert('1, '1, '1, 32'sh7fff_ffff);
    send_insert('0, '0, '0, 32'sh8000_0000);
    send_insert(DRAW_W'(24'h5a5a5a), TILE_W'(35'h2_aaaa_aaaa), TILE_W'(35'h5_5555_5555), -1);
    send_op(OP_POP, random_entry());
    send_op(OP_DRAIN, random_entry());
  endtask

  // Equal keys: order follows the strict compares
  task automatic test_equal_keys();
    send_insert(7, 35'h1, 35'h11, 32'sd1);
    send_insert(7, 35'h2, 35'h0, 32'sd2);
    send_insert(3, 35'h3, 35'h33, 32'sd3);
    send_insert(7, 35'h4, 35'h44, 32'sd4);
    send_insert(3, 35'h5, 35'h55, 32'sd5);
    send_op(OP_POP, random_entry());
    send_op(OP_POP, random_entry());
    send_op(OP_DRAIN, random_entry());
  endtask

  // Clear drops stored entries
  task automatic test_clear();
    send_insert(100, 35'h7, 35'h8, 32'sd9);
    send_insert(50, 35'h9, 35'ha, -32'sd9);
    send_op(OP_CLEAR, random_entry());
    send_op(OP_POP, random_entry());
  endtask

  // Capacity extremes and a capacity lowered below the count
  task automatic test_capacity_limits();
    int i;
    set_capacity(0);
    for (i = 0; i < 4; i++) send_op(OP_INSERT, random_entry());
    send_op(OP_DRAIN, random_entry());
    set_capacity(127);
    for (i = 0; i < 20; i++) send_op(OP_INSERT, random_entry());
    send_op(OP_DRAIN, random_entry());
    set_capacity(16);
    for (i = 0; i < 12; i++) send_op(OP_INSERT, random_entry());
    set_capacity(3);
    for (i = 0; i < 3; i++) send_op(OP_INSERT, random_entry());
    send_op(OP_POP, random_entry());
    send_op(OP_DRAIN, random_entry());
  endtask

  // Receiver holds off while pops keep arriving, so the input backs up
  task automatic test_output_stall();
    int i;
    set_capacity(16);
    tx_idle_on = 1'b0;
    for (i = 0; i < 14; i++) send_op(OP_INSERT, random_entry());
    rx_hold_req = 300;
    for (i = 0; i < 6; i++) send_op(OP_POP, random_entry());
    send_op(OP_DRAIN, random_entry());
    for (i = 0; i < 4; i++) send_op(OP_INSERT, random_entry());
    send_op(OP_POP, random_entry());
    tx_idle_on = 1'b1;
  endtask

  // Random traffic across several capacity settings
  task automatic test_random_traffic();
    logic [CAP_W-1:0] caps [8];
    int p;
    int i;
    caps = '{1, 2, 5, 16, 0, 127, 9, CAP_W'($urandom_range(1, 64))};
    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      for (i = 0; i < 22; i++) send_op(random_op(), random_entry());
    end
  endtask

  // Both sides at full rate
  task automatic test_back_to_back();
    int i;
    set_capacity(16);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (i = 0; i < 40; i++) send_op(random_op(), random_entry());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst             <= 1'b1;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    op              <= OP_INSERT;
    draws           <= '0;
    leave_tiles     <= '0;
    exchanged_tiles <= '0;
    equity          <= '0;
    shadow_count = 0;
    shadow_cap   = CAP_RESET;
    fail_count   = 0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    rx_hold_req  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_heap();
    test_field_extremes();
    test_equal_keys();
    test_clear();
    test_capacity_limits();
    test_output_stall();
    test_random_traffic();
    test_back_to_back();

    // Drain what is owed, then watch for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_pops.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[bounded_top_k_min_heap.f]
rtl/core/btk_pkg.sv
rtl/core/btk_key_cmp.sv
rtl/core/btk_seq.sv
rtl/core/bounded_top_k_min_heap.sv
rtl/core/btk_checker.sv
tb/bounded_top_k_min_heap_test.sv
